FILE: src/telemetry_frame_encoder_top_defines.svh
// Assertion macros for the telemetry frame encoder.
// Used by telemetry_frame_encoder_top; expects clk_i and rst_ni in scope.
`ifndef TELEMETRY_FRAME_ENCODER_TOP_DEFINES_SVH
`define TELEMETRY_FRAME_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TFE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("telemetry frame encoder: check failed");

// Next-cycle implication, checked outside reset.
`define TFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("telemetry frame encoder: check failed");

`endif

FILE: src/tfe_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the telemetry frame encoder.
// No dependencies; used by every module of the block.
package tfe_pkg;

  localparam logic [7:0] StartMark = 8'h7E;
  localparam logic [7:0] EscMark   = 8'h7D;
  localparam logic [7:0] EscFlip   = 8'h20;
  localparam logic [7:0] FrameData = 8'h10;

  localparam int unsigned QueueDepth = 2;

  // Byte positions within an unstuffed frame.
  localparam int unsigned PosW = 4;
  localparam logic [PosW-1:0] PosStart = 4'd0;
  localparam logic [PosW-1:0] PosDev   = 4'd1;
  localparam logic [PosW-1:0] PosType  = 4'd2;
  localparam logic [PosW-1:0] PosSid0  = 4'd3;
  localparam logic [PosW-1:0] PosSid1  = 4'd4;
  localparam logic [PosW-1:0] PosVal0  = 4'd5;
  localparam logic [PosW-1:0] PosVal1  = 4'd6;
  localparam logic [PosW-1:0] PosVal2  = 4'd7;
  localparam logic [PosW-1:0] PosVal3  = 4'd8;
  localparam logic [PosW-1:0] PosCsum  = 4'd9;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [15:0] sensor_id;
    logic [31:0] data_value;
    logic [7:0]  csum;
  } frame_t;

  // Eight-bit sum with end-around carry.
  function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'b0, s[8]};
  endfunction

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == StartMark) || (b == EscMark);
  endfunction

endpackage

FILE: src/tfe_front.sv
`timescale 1ns / 1ps
// Front end: accept input transactions, form the checksum, hold one frame.
// Depends on tfe_pkg.
module tfe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          device_id_i,
  input  logic [15:0]         sensor_id_i,
  input  logic [31:0]         data_value_i,
  output logic                push_o,
  input  logic                push_ready_i,
  output tfe_pkg::frame_t     frame_o
);

  logic            hold_q, hold_d;
  tfe_pkg::frame_t frame_q;
  logic            accept;
  logic [7:0]      s01, s23, s45, s0123, s456, sum;

  // Checksum as a tree of end-around adds; the frame type byte keeps it nonzero.
  assign s01   = tfe_pkg::ones_add(tfe_pkg::FrameData, sensor_id_i[7:0]);
  assign s23   = tfe_pkg::ones_add(sensor_id_i[15:8], data_value_i[7:0]);
  assign s45   = tfe_pkg::ones_add(data_value_i[15:8], data_value_i[23:16]);
  assign s0123 = tfe_pkg::ones_add(s01, s23);
  assign s456  = tfe_pkg::ones_add(s45, data_value_i[31:24]);
  assign sum   = tfe_pkg::ones_add(s0123, s456);

  assign push_o     = hold_q;
  assign in_stall_o = hold_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign frame_o    = frame_q;

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_o && push_ready_i) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q.device_id  <= device_id_i;
      frame_q.sensor_id  <= sensor_id_i;
      frame_q.data_value <= data_value_i;
      frame_q.csum       <= ~sum;
    end
  end

endmodule

FILE: src/tfe_queue.sv
`timescale 1ns / 1ps
// Short frame queue between the front and the back end.
// Depends on tfe_pkg.
module tfe_queue #(
  parameter int unsigned DEPTH = tfe_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  tfe_pkg::frame_t frame_i,
  output logic            valid_o,
  input  logic            pop_i,
  output tfe_pkg::frame_t frame_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tfe_pkg::frame_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign frame_o = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= frame_i;
    end
  end

endmodule

FILE: src/tfe_back.sv
`timescale 1ns / 1ps
// Back end: walk a frame byte by byte, insert escapes, drive the output register.
// Depends on tfe_pkg.
module tfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  input  tfe_pkg::frame_t     frame_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          tx_byte_o,
  output logic                last_byte_o
);

  logic [tfe_pkg::PosW-1:0] pos_q, pos_d;
  logic                     esc_q, esc_d;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               tx_byte_q, tx_byte_d;
  logic                     last_q, last_d;
  logic [7:0]               cur;
  logic                     stuffable, load, emit;

  always_comb begin
    unique case (pos_q)
      tfe_pkg::PosStart: cur = tfe_pkg::StartMark;
      tfe_pkg::PosDev:   cur = frame_i.device_id;
      tfe_pkg::PosType:  cur = tfe_pkg::FrameData;
      tfe_pkg::PosSid0:  cur = frame_i.sensor_id[7:0];
      tfe_pkg::PosSid1:  cur = frame_i.sensor_id[15:8];
      tfe_pkg::PosVal0:  cur = frame_i.data_value[7:0];
      tfe_pkg::PosVal1:  cur = frame_i.data_value[15:8];
      tfe_pkg::PosVal2:  cur = frame_i.data_value[23:16];
      tfe_pkg::PosVal3:  cur = frame_i.data_value[31:24];
      tfe_pkg::PosCsum:  cur = frame_i.csum;
      default:           cur = tfe_pkg::StartMark;
    endcase
  end

  // Start byte and device id go out raw.
  assign stuffable = (pos_q != tfe_pkg::PosStart) && (pos_q != tfe_pkg::PosDev) &&
                     tfe_pkg::needs_esc(cur);
  assign load = !out_valid_q || !out_stall_i;
  assign emit = load && frame_valid_i;
  assign pop_o = emit && (pos_q == tfe_pkg::PosCsum) && !(stuffable && !esc_q);

  always_comb begin
    pos_d       = pos_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q;
    tx_byte_d   = tx_byte_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = frame_valid_i;
    end
    if (emit) begin
      if (stuffable && !esc_q) begin
        tx_byte_d = tfe_pkg::EscMark;
        last_d    = 1'b0;
        esc_d     = 1'b1;
      end else begin
        tx_byte_d = esc_q ? (cur & ~tfe_pkg::EscFlip) : cur;
        last_d    = (pos_q == tfe_pkg::PosCsum);
        esc_d     = 1'b0;
        pos_d     = (pos_q == tfe_pkg::PosCsum) ? tfe_pkg::PosStart : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= tfe_pkg::PosStart;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_byte_q <= tx_byte_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

endmodule

FILE: src/telemetry_frame_encoder_top.sv
`timescale 1ns / 1ps
// Telemetry frame encoder. Each input transaction (device id, sensor id, 32-bit
// value) becomes one data frame sent as 10 to 17 output transactions, one byte
// each: start byte 0x7E and device id raw, then type byte 0x10, sensor id and
// value low byte first, and the inverted end-around-carry checksum, with 0x7E
// and 0x7D in those last eight bytes escaped as 0x7D plus the byte with bit 5
// cleared. last_byte_o flags the final byte (for an escaped checksum, its
// second half). The back end emits one byte per cycle while out_stall_i is low
// and a frame is queued; that byte sequencer sets the sustained rate. The
// front end takes a new transaction while earlier frames are still queued, so
// up to QUEUE_DEPTH frames can be accepted ahead of the one on the wire.
// Frames go from the front hold register via the queue to the output register.
// Depends on tfe_pkg, tfe_front, tfe_queue, tfe_back and the defines header.
`include "telemetry_frame_encoder_top_defines.svh"

module telemetry_frame_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = tfe_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  device_id_i,
  input  logic [15:0] sensor_id_i,
  input  logic [31:0] data_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o
);

  // Front to queue
  logic            q_push, q_ready;
  tfe_pkg::frame_t front_frame;
  // Queue to back
  logic            q_valid, q_pop;
  tfe_pkg::frame_t head_frame;

  // Accept and checksum; hold one frame until the queue has room.
  tfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .device_id_i  (device_id_i),
    .sensor_id_i  (sensor_id_i),
    .data_value_i (data_value_i),
    .push_o       (q_push),
    .push_ready_i (q_ready),
    .frame_o      (front_frame)
  );

  // Decouple the two sides so each can stall on its own.
  tfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ready_o (q_ready),
    .frame_i (front_frame),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .frame_o (head_frame)
  );

  // Serialise and escape; release the queue head on the final byte.
  tfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (q_valid),
    .frame_i       (head_frame),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_byte_o     (tx_byte_o),
    .last_byte_o   (last_byte_o)
  );

  // Pop only a frame that is actually queued.
  `TFE_ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid)
  // Push only into a queue with room.
  `TFE_ASSERT_IMPL(a_push_room, q_push && !in_stall_o, q_ready)
  // The flagged byte is never a raw marker: escapes always complete first.
  `TFE_ASSERT_IMPL(a_last_unstuffed, out_valid_o && last_byte_o,
                   tx_byte_o != tfe_pkg::StartMark && tx_byte_o != tfe_pkg::EscMark)

endmodule
